@@ hdl/mhr_pkg.sv @@
// Package for the magnetometer heading ring block.
// Holds widths, heading constants, the CORDIC arctangent table, the LED ring table and
// the sequencer state type. No dependencies.
package mhr_pkg;

    // Fixed field widths
    localparam int MAG_W  = 16;
    localparam int HEAD_W = 13;
    localparam int LED_W  = 3;

    // Heading resolution and ring size
    localparam int FRAC_BITS    = 4;
    localparam int RING_ENTRIES = 20;
    localparam int RING_IDX_W   = $clog2(RING_ENTRIES);

    // CORDIC datapath sizing: magnitudes scaled by 2^16, angle in 2^-16 degree
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int SCALE_BITS   = 16;
    localparam int CORDIC_W     = MAG_W + SCALE_BITS + 3;
    localparam int ANG_W        = 25;
    localparam int ROUND_SHIFT  = SCALE_BITS - FRAC_BITS;

    // Heading constants in 2^-FRAC_BITS degree
    localparam logic [HEAD_W-1:0] DEG_90   = HEAD_W'(90 << FRAC_BITS);
    localparam logic [HEAD_W-1:0] DEG_180  = HEAD_W'(180 << FRAC_BITS);
    localparam logic [HEAD_W-1:0] DEG_270  = HEAD_W'(270 << FRAC_BITS);
    localparam logic [HEAD_W-1:0] DEG_360  = HEAD_W'(360 << FRAC_BITS);

    // Hard-iron offsets after reset
    localparam logic signed [MAG_W-1:0] OFFSET_X_RST = MAG_W'(785);
    localparam logic signed [MAG_W-1:0] OFFSET_Y_RST = MAG_W'(307);

    // Item opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_ENTER  = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROT,
        ST_DONE
    } mhr_state_t;

    // Status of the shared CORDIC unit
    typedef struct packed {
        logic busy;
        logic done;
    } mhr_cordic_stat_t;

    // One LED ring entry: position and upper heading bound in whole degrees
    typedef struct packed {
        logic [LED_W-1:0] row;
        logic [LED_W-1:0] col;
        logic [8:0]       deg;
    } mhr_ring_pos_t;

    localparam mhr_ring_pos_t RING_TAB [RING_ENTRIES] = '{
        '{3'd4, 3'd0, 9'd18},  '{3'd5, 3'd0, 9'd30},  '{3'd6, 3'd1, 9'd54},
        '{3'd7, 3'd2, 9'd72},  '{3'd7, 3'd3, 9'd90},  '{3'd7, 3'd4, 9'd108},
        '{3'd7, 3'd5, 9'd120}, '{3'd6, 3'd6, 9'd144}, '{3'd5, 3'd7, 9'd162},
        '{3'd4, 3'd7, 9'd180}, '{3'd3, 3'd7, 9'd198}, '{3'd2, 3'd7, 9'd216},
        '{3'd1, 3'd6, 9'd240}, '{3'd0, 3'd5, 9'd252}, '{3'd0, 3'd4, 9'd270},
        '{3'd0, 3'd3, 9'd288}, '{3'd0, 3'd2, 9'd306}, '{3'd1, 3'd1, 9'd324},
        '{3'd2, 3'd0, 9'd342}, '{3'd3, 3'd0, 9'd360}
    };

    // Rounded atan(2^-i) in 2^-16 degree
    function automatic logic [ANG_W-1:0] atan_step(input logic [STEP_W-1:0] i);
        logic [ANG_W-1:0] v;
        case (i)
            4'd0:    v = ANG_W'(2949120);
            4'd1:    v = ANG_W'(1740967);
            4'd2:    v = ANG_W'(919879);
            4'd3:    v = ANG_W'(466945);
            4'd4:    v = ANG_W'(234379);
            4'd5:    v = ANG_W'(117304);
            4'd6:    v = ANG_W'(58666);
            4'd7:    v = ANG_W'(29335);
            4'd8:    v = ANG_W'(14668);
            4'd9:    v = ANG_W'(7334);
            4'd10:   v = ANG_W'(3667);
            4'd11:   v = ANG_W'(1833);
            4'd12:   v = ANG_W'(917);
            4'd13:   v = ANG_W'(458);
            4'd14:   v = ANG_W'(229);
            4'd15:   v = ANG_W'(115);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/mhr_if.sv @@
// Valid/ready channel interfaces for the magnetometer heading ring block.
// Depends on mhr_pkg for the field widths.
interface mhr_sample_if;
    import mhr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic signed [MAG_W-1:0] mag_x;
    logic signed [MAG_W-1:0] mag_y;

    modport source (output valid, opcode, mag_x, mag_y, input ready);
    modport sink   (input valid, opcode, mag_x, mag_y, output ready);
endinterface

interface mhr_result_if;
    import mhr_pkg::*;

    logic              valid;
    logic              ready;
    logic              calibrating;
    logic              heading_valid;
    logic [HEAD_W-1:0] heading;
    logic [LED_W-1:0]  led_row;
    logic [LED_W-1:0]  led_col;

    modport source (output valid, calibrating, heading_valid, heading, led_row, led_col,
                    input ready);
    modport sink   (input valid, calibrating, heading_valid, heading, led_row, led_col,
                    output ready);
endinterface

@@ hdl/magnetometer_heading_ring.sv @@
// Magnetometer compass heading with hard-iron calibration and LED ring position.
// Depends on mhr_pkg, mhr_if (channels), mhr_cordic and mhr_ring.
//
// Usage:
//   sample: one transfer per item. opcode OP_SAMPLE carries a raw X/Y reading,
//   OP_ENTER toggles between run and calibration mode (X/Y ignored).
//   result: exactly one transfer per item: mode, heading_valid, heading in
//   1/16 degree (0..5760) and the LED ring row/column.
// Sequencing:
//   A run-mode sample passes from ST_IDLE through ST_ROT, where the 16 CORDIC steps
//   run on the shared shift/add unit, and ST_DONE, where its result is loaded into
//   the output register once that register is free. Enter-key items and calibration
//   samples go from ST_IDLE straight to ST_DONE. A new item is accepted only after
//   the sequencer is through with the last one and back in ST_IDLE.
//   sample.ready is high only while the sequencer is idle.
// Reset: run mode, offsets 785/307, min/max cleared, last heading and ring position 0,
//   no result pending.
// Stall: a result waits in the output register while result.ready is low; the next
//   item is still accepted and processed, and its result waits until the register frees.
module magnetometer_heading_ring (
    input logic   clk,
    input logic   rst_n,
    mhr_sample_if.sink   sample,
    mhr_result_if.source result
);
    import mhr_pkg::*;

    mhr_state_t state_reg, state_next;

    logic                    mode_reg, mode_next;
    logic signed [MAG_W-1:0] offset_x_reg, offset_x_next;
    logic signed [MAG_W-1:0] offset_y_reg, offset_y_next;
    logic signed [MAG_W-1:0] min_x_reg, min_x_next;
    logic signed [MAG_W-1:0] max_x_reg, max_x_next;
    logic signed [MAG_W-1:0] min_y_reg, min_y_next;
    logic signed [MAG_W-1:0] max_y_reg, max_y_next;
    logic [LED_W-1:0]        last_row_reg, last_row_next;
    logic [LED_W-1:0]        last_col_reg, last_col_next;
    logic [HEAD_W-1:0]       last_heading_reg, last_heading_next;
    logic                    hv_reg, hv_next;
    logic signed [MAG_W-1:0] dx_reg, dx_next;
    logic signed [MAG_W-1:0] dy_reg, dy_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    out_cal_reg, out_hv_reg;
    logic [HEAD_W-1:0]       out_heading_reg;
    logic [LED_W-1:0]        out_row_reg, out_col_reg;

    logic                    accept;
    logic                    out_free;
    logic                    load_out;
    logic                    cordic_start;
    logic signed [MAG_W-1:0] dx_in, dy_in;
    logic [MAG_W-1:0]        a_in, b_in;
    logic signed [MAG_W:0]   sum_x, sum_y, half_x, half_y;
    mhr_cordic_stat_t        cordic_stat;
    logic [HEAD_W-1:0]       base;
    logic [HEAD_W-1:0]       heading_new;
    logic [LED_W-1:0]        ring_row, ring_col;

    assign sample.ready = (state_reg == ST_IDLE);
    assign accept       = sample.valid && sample.ready;
    assign out_free     = !out_valid_reg || result.ready;
    assign load_out     = (state_reg == ST_DONE) && out_free;
    assign cordic_start = accept && (sample.opcode == OP_SAMPLE) && !mode_reg;

    // Remove hard-iron offset with 16-bit wrap, take magnitudes
    always_comb
    begin
        dx_in = sample.mag_x - offset_x_reg;
        dy_in = sample.mag_y - offset_y_reg;
        a_in  = dx_in[MAG_W-1] ? MAG_W'(-dx_in) : MAG_W'(dx_in);
        b_in  = dy_in[MAG_W-1] ? MAG_W'(-dy_in) : MAG_W'(dy_in);
    end

    // Offset = (max + min) / 2, truncated toward zero
    always_comb
    begin
        sum_x  = (MAG_W+1)'(max_x_reg) + (MAG_W+1)'(min_x_reg);
        sum_y  = (MAG_W+1)'(max_y_reg) + (MAG_W+1)'(min_y_reg);
        half_x = (sum_x >>> 1) + signed'((MAG_W+1)'(sum_x[MAG_W] & sum_x[0]));
        half_y = (sum_y >>> 1) + signed'((MAG_W+1)'(sum_y[MAG_W] & sum_y[0]));
    end

    mhr_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .a     (a_in),
        .b     (b_in),
        .stat  (cordic_stat),
        .base  (base)
    );

    // Place the first-quadrant angle in its quadrant
    always_comb
    begin
        if (dx_reg > 0)
        begin
            if (dy_reg > 0)
                heading_new = base;
            else if (dy_reg < 0)
                heading_new = DEG_360 - base;
            else
                heading_new = '0;
        end
        else if (dx_reg == 0)
        begin
            if (dy_reg > 0)
                heading_new = DEG_90;
            else if (dy_reg < 0)
                heading_new = DEG_270;
            else
                heading_new = '0;
        end
        else
        begin
            if (dy_reg > 0)
                heading_new = DEG_180 - base;
            else if (dy_reg < 0)
                heading_new = DEG_180 + base;
            else
                heading_new = DEG_180;
        end
    end

    mhr_ring u_ring (
        .heading (heading_new),
        .led_row (ring_row),
        .led_col (ring_col)
    );

    // Sequencer: next state and state updates
    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        offset_x_next     = offset_x_reg;
        offset_y_next     = offset_y_reg;
        min_x_next        = min_x_reg;
        max_x_next        = max_x_reg;
        min_y_next        = min_y_reg;
        max_y_next        = max_y_reg;
        last_row_next     = last_row_reg;
        last_col_next     = last_col_reg;
        last_heading_next = last_heading_reg;
        hv_next           = hv_reg;
        dx_next           = dx_reg;
        dy_next           = dy_reg;
        out_valid_next    = out_valid_reg && !result.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    hv_next    = 1'b0;
                    state_next = ST_DONE;
                    if (sample.opcode == OP_ENTER)
                    begin
                        if (!mode_reg)
                        begin
                            // enter calibration, restart tracking from zero
                            mode_next  = 1'b1;
                            min_x_next = '0;
                            max_x_next = '0;
                            min_y_next = '0;
                            max_y_next = '0;
                        end
                        else
                        begin
                            // leave calibration, load new offsets
                            mode_next     = 1'b0;
                            offset_x_next = half_x[MAG_W-1:0];
                            offset_y_next = half_y[MAG_W-1:0];
                        end
                    end
                    else if (mode_reg)
                    begin
                        // track raw extremes
                        if (sample.mag_x > max_x_reg)
                            max_x_next = sample.mag_x;
                        if (sample.mag_x < min_x_reg)
                            min_x_next = sample.mag_x;
                        if (sample.mag_y > max_y_reg)
                            max_y_next = sample.mag_y;
                        if (sample.mag_y < min_y_reg)
                            min_y_next = sample.mag_y;
                    end
                    else
                    begin
                        dx_next    = dx_in;
                        dy_next    = dy_in;
                        state_next = ST_ROT;
                    end
                end
            end

            ST_ROT:
            begin
                if (cordic_stat.done)
                begin
                    last_heading_next = heading_new;
                    last_row_next     = ring_row;
                    last_col_next     = ring_col;
                    hv_next           = 1'b1;
                    state_next        = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            mode_reg         <= 1'b0;
            offset_x_reg     <= OFFSET_X_RST;
            offset_y_reg     <= OFFSET_Y_RST;
            min_x_reg        <= '0;
            max_x_reg        <= '0;
            min_y_reg        <= '0;
            max_y_reg        <= '0;
            last_row_reg     <= '0;
            last_col_reg     <= '0;
            last_heading_reg <= '0;
            hv_reg           <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            mode_reg         <= mode_next;
            offset_x_reg     <= offset_x_next;
            offset_y_reg     <= offset_y_next;
            min_x_reg        <= min_x_next;
            max_x_reg        <= max_x_next;
            min_y_reg        <= min_y_next;
            max_y_reg        <= max_y_next;
            last_row_reg     <= last_row_next;
            last_col_reg     <= last_col_next;
            last_heading_reg <= last_heading_next;
            hv_reg           <= hv_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Hold sample deltas and the output payload
    always_ff @(posedge clk)
    begin
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        if (load_out)
        begin
            out_cal_reg     <= mode_reg;
            out_hv_reg      <= hv_reg;
            out_heading_reg <= last_heading_reg;
            out_row_reg     <= last_row_reg;
            out_col_reg     <= last_col_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.calibrating   = out_cal_reg;
    assign result.heading_valid = out_hv_reg;
    assign result.heading       = out_heading_reg;
    assign result.led_row       = out_row_reg;
    assign result.led_col       = out_col_reg;

    // The shared CORDIC unit runs only while the sequencer waits on it
    a_cordic_in_rot: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_stat.busy |-> state_reg == ST_ROT)
        else $error("CORDIC busy outside rotation state");

    // A new heading never comes with calibration mode
    a_hv_run_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.heading_valid) |-> !result.calibrating)
        else $error("heading_valid reported in calibration mode");

    // Heading stays within 0..360 degrees
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.heading <= DEG_360)
        else $error("heading beyond 360 degrees");

    // Leaving the rotation state always follows the CORDIC done pulse
    a_rot_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROT && !cordic_stat.done) |=> state_reg == ST_ROT)
        else $error("rotation state left before CORDIC finished");

endmodule

@@ hdl/mhr_cordic.sv @@
// Iterative vectoring CORDIC: first-quadrant arctangent of b/a, one step per cycle.
// Depends on mhr_pkg for sizing, the atan table and the status struct.
module mhr_cordic (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [mhr_pkg::MAG_W-1:0] a,
    input  logic [mhr_pkg::MAG_W-1:0] b,
    output mhr_pkg::mhr_cordic_stat_t stat,
    output logic [mhr_pkg::HEAD_W-1:0] base
);
    import mhr_pkg::*;

    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic signed [ANG_W-1:0]    z_reg, z_next;
    logic [STEP_W-1:0]          cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;

    logic signed [CORDIC_W-1:0] xs, ys;
    logic signed [ANG_W-1:0]    ang, zc, rnd;

    // Shared shift/add step
    always_comb
    begin
        xs        = x_reg >>> cnt_reg;
        ys        = y_reg >>> cnt_reg;
        ang       = signed'(atan_step(cnt_reg));
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = signed'({3'b000, a, SCALE_BITS'(0)});
            y_next    = signed'({3'b000, b, SCALE_BITS'(0)});
            z_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // rotate toward the x axis and accumulate the angle
            if (!y_reg[CORDIC_W-1])
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + ang;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - ang;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    // Clamp at zero, round half up to heading units, clamp at 90 degrees
    always_comb
    begin
        zc  = z_reg[ANG_W-1] ? '0 : z_reg;
        rnd = (zc + ANG_W'(1 << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        if (rnd > signed'(ANG_W'(DEG_90)))
            base = DEG_90;
        else
            base = rnd[HEAD_W-1:0];
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ hdl/mhr_ring.sv @@
// LED ring lookup: picks the first ring entry whose bound is not below the heading.
// Depends on mhr_pkg for the ring table.
module mhr_ring (
    input  logic [mhr_pkg::HEAD_W-1:0] heading,
    output logic [mhr_pkg::LED_W-1:0]  led_row,
    output logic [mhr_pkg::LED_W-1:0]  led_col
);
    import mhr_pkg::*;

    logic [RING_IDX_W-1:0] pick;

    // Priority search, lowest index wins; fall back to the last entry
    always_comb
    begin
        pick = RING_IDX_W'(RING_ENTRIES - 1);
        for (int i = RING_ENTRIES - 1; i >= 0; i--)
        begin
            if (heading <= (HEAD_W'(RING_TAB[i].deg) << FRAC_BITS))
                pick = RING_IDX_W'(i);
        end
        led_row = RING_TAB[pick].row;
        led_col = RING_TAB[pick].col;
    end

endmodule

@@ sim/magnetometer_heading_ring_tb.sv @@
// Self-checking testbench for magnetometer_heading_ring: directed table, then random items.
// Predicts heading, calibration mode and LED ring position per transfer and scores results.
// Depends on mhr_pkg, the mhr_if channel interfaces and the magnetometer_heading_ring RTL.
module magnetometer_heading_ring_tb;
    import mhr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 40;
    localparam int DEG90_I      = 90 << FRAC_BITS;

    // Rounded atan(2^-i) in 2^-16 degree
    localparam longint ATAN_TAB [CORDIC_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    typedef struct packed {
        logic              calibrating;
        logic              heading_valid;
        logic [HEAD_W-1:0] heading;
        logic [LED_W-1:0]  led_row;
        logic [LED_W-1:0]  led_col;
    } heading_result_t;

    typedef struct packed {
        logic                    opcode;
        logic signed [MAG_W-1:0] mag_x;
        logic signed [MAG_W-1:0] mag_y;
        logic                    typed;
        heading_result_t         want;
    } compass_row_t;

    // Directed rows; hand-typed results only where they are obvious
    localparam int DIRECTED_ROWS = 25;
    localparam compass_row_t DIRECTED [DIRECTED_ROWS] = '{
        // reset offsets: zero vector, then the four axis directions
        '{OP_SAMPLE, 16'sd785, 16'sd307, 1'b1, '{1'b0, 1'b1, 13'd0, 3'd4, 3'd0}},
        '{OP_SAMPLE, 16'sd885, 16'sd307, 1'b1, '{1'b0, 1'b1, 13'd0, 3'd4, 3'd0}},
        '{OP_SAMPLE, 16'sd785, 16'sd407, 1'b1, '{1'b0, 1'b1, 13'd1440, 3'd7, 3'd3}},
        '{OP_SAMPLE, 16'sd785, 16'sd207, 1'b1, '{1'b0, 1'b1, 13'd4320, 3'd0, 3'd4}},
        '{OP_SAMPLE, 16'sd685, 16'sd307, 1'b1, '{1'b0, 1'b1, 13'd2880, 3'd4, 3'd7}},
        // most negative X after offset, Y on axis
        '{OP_SAMPLE, -16'sd31983, 16'sd307, 1'b1, '{1'b0, 1'b1, 13'd2880, 3'd4, 3'd7}},
        // raw extremes, wrapping offset subtraction
        '{OP_SAMPLE, -16'sd32768, -16'sd32768, 1'b0, '0},
        '{OP_SAMPLE, 16'sd32767, 16'sd32767, 1'b0, '0},
        '{OP_SAMPLE, -16'sd31983, -16'sd32461, 1'b0, '0},
        '{OP_SAMPLE, 16'sd786, 16'sd306, 1'b0, '0},
        '{OP_SAMPLE, 16'sd0, 16'sd0, 1'b0, '0},
        // calibrate on full-scale extremes: offsets truncate toward zero to 0/0
        '{OP_ENTER, 16'sd12345, -16'sd4321, 1'b0, '0},
        '{OP_SAMPLE, 16'sd32767, -16'sd32768, 1'b0, '0},
        '{OP_SAMPLE, -16'sd32768, 16'sd32767, 1'b0, '0},
        '{OP_SAMPLE, 16'sd100, 16'sd200, 1'b0, '0},
        '{OP_ENTER, 16'sd0, 16'sd0, 1'b0, '0},
        '{OP_SAMPLE, 16'sd5, 16'sd0, 1'b1, '{1'b0, 1'b1, 13'd0, 3'd4, 3'd0}},
        '{OP_SAMPLE, 16'sd0, 16'sd0, 1'b1, '{1'b0, 1'b1, 13'd0, 3'd4, 3'd0}},
        // calibrate on small negatives: offsets -3/-1 when truncated toward zero
        '{OP_ENTER, -16'sd1, -16'sd1, 1'b1, '{1'b1, 1'b0, 13'd0, 3'd4, 3'd0}},
        '{OP_SAMPLE, -16'sd7, -16'sd3, 1'b1, '{1'b1, 1'b0, 13'd0, 3'd4, 3'd0}},
        '{OP_ENTER, 16'sd32767, 16'sd32767, 1'b1, '{1'b0, 1'b0, 13'd0, 3'd4, 3'd0}},
        '{OP_SAMPLE, -16'sd3, -16'sd1, 1'b1, '{1'b0, 1'b1, 13'd0, 3'd4, 3'd0}},
        // tiny negative Y against full X: heading clamps to 360 degrees
        '{OP_SAMPLE, 16'sd32764, -16'sd2, 1'b1, '{1'b0, 1'b1, 13'd5760, 3'd3, 3'd0}},
        '{OP_SAMPLE, -16'sd32768, 16'sd0, 1'b0, '0},
        '{OP_SAMPLE, 16'sd32764, 16'sd32766, 1'b0, '0}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   calm  = 1'b0;
    int   mismatch_count = 0;

    heading_result_t expected_headings [$];

    // Compass state mirror
    logic                    cal_mode;
    logic signed [MAG_W-1:0] off_x, off_y;
    logic signed [MAG_W-1:0] lo_x, hi_x, lo_y, hi_y;
    logic [HEAD_W-1:0]       last_heading;
    logic [LED_W-1:0]        last_row, last_col;

    mhr_sample_if sample_ch ();
    mhr_result_if result_ch ();

    magnetometer_heading_ring u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // First-quadrant angle of (a, b) in 2^-FRAC_BITS degree by CORDIC vectoring
    function automatic int cordic_base(input int a, input int b);
        longint xr, yr, ang, xs, ys, r;
        int     i;
        xr  = longint'(a) <<< SCALE_BITS;
        yr  = longint'(b) <<< SCALE_BITS;
        ang = 0;
        for (i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = xr >>> i;
            ys = yr >>> i;
            if (yr >= 0)
            begin
                xr  = xr + ys;
                yr  = yr - xs;
                ang = ang + ATAN_TAB[i];
            end
            else
            begin
                xr  = xr - ys;
                yr  = yr + xs;
                ang = ang - ATAN_TAB[i];
            end
        end
        if (ang < 0)
            ang = 0;
        r = (ang + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        return (r > DEG90_I) ? DEG90_I : int'(r);
    endfunction

    function automatic void reset_compass();
        cal_mode     = 1'b0;
        off_x        = OFFSET_X_RST;
        off_y        = OFFSET_Y_RST;
        lo_x         = '0;
        hi_x         = '0;
        lo_y         = '0;
        hi_y         = '0;
        last_heading = '0;
        last_row     = '0;
        last_col     = '0;
    endfunction

    // Advance the compass state by one item and return its result
    function automatic heading_result_t advance_compass(input logic op,
                                                        input logic signed [MAG_W-1:0] mx,
                                                        input logic signed [MAG_W-1:0] my);
        logic signed [MAG_W-1:0] dx, dy;
        int                      a, b, base, h, pick, i;
        logic                    fresh;
        heading_result_t         res;
        fresh = 1'b0;
        if (op == OP_ENTER)
        begin
            if (!cal_mode)
            begin
                cal_mode = 1'b1;
                lo_x = '0;
                hi_x = '0;
                lo_y = '0;
                hi_y = '0;
            end
            else
            begin
                cal_mode = 1'b0;
                off_x = MAG_W'((int'(hi_x) + int'(lo_x)) / 2);
                off_y = MAG_W'((int'(hi_y) + int'(lo_y)) / 2);
            end
        end
        else if (cal_mode)
        begin
            if (mx > hi_x) hi_x = mx;
            if (mx < lo_x) lo_x = mx;
            if (my > hi_y) hi_y = my;
            if (my < lo_y) lo_y = my;
        end
        else
        begin
            dx = mx - off_x;
            dy = my - off_y;
            a  = (dx < 0) ? -int'(dx) : int'(dx);
            b  = (dy < 0) ? -int'(dy) : int'(dy);
            if (b == 0)
                base = 0;
            else if (a == 0)
                base = DEG90_I;
            else
                base = cordic_base(a, b);

            // place the base angle in its quadrant
            if (dx > 0)
                h = (dy > 0) ? base : ((dy < 0) ? int'(DEG_360) - base : 0);
            else if (dx == 0)
                h = (dy > 0) ? int'(DEG_90) : ((dy < 0) ? int'(DEG_270) : 0);
            else
                h = (dy > 0) ? int'(DEG_180) - base :
                    ((dy < 0) ? int'(DEG_180) + base : int'(DEG_180));
            if (h < 0)
                h = 0;
            if (h > int'(DEG_360))
                h = int'(DEG_360);

            // pick the first ring entry at or above the heading
            pick = RING_ENTRIES - 1;
            for (i = 0; i < RING_ENTRIES; i++)
            begin
                if (h <= (int'(RING_TAB[i].deg) << FRAC_BITS))
                begin
                    pick = i;
                    break;
                end
            end
            last_row     = RING_TAB[pick].row;
            last_col     = RING_TAB[pick].col;
            last_heading = HEAD_W'(h);
            fresh        = 1'b1;
        end
        res.calibrating   = cal_mode;
        res.heading_valid = fresh;
        res.heading       = last_heading;
        res.led_row       = last_row;
        res.led_col       = last_col;
        return res;
    endfunction

    // Drive one item, wait for its transfer, then queue its expected result
    task automatic transfer_item(input logic op, input logic signed [MAG_W-1:0] mx,
                                 input logic signed [MAG_W-1:0] my, input logic typed,
                                 input heading_result_t typed_want);
        heading_result_t want;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.opcode <= op;
        sample_ch.mag_x  <= mx;
        sample_ch.mag_y  <= my;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
        want = advance_compass(op, mx, my);
        if (typed)
            want = typed_want;
        expected_headings.push_back(want);
    endtask

    // Stall the result side in random bursts
    initial
    begin
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 4) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Score each result transfer against the oldest expectation
    always @(posedge clk)
    begin : score_result
        heading_result_t want, got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = '{result_ch.calibrating, result_ch.heading_valid, result_ch.heading,
                    result_ch.led_row, result_ch.led_col};
            if (expected_headings.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result transfer with none expected: cal=%0d hv=%0d h=%0d rc=%0d,%0d",
                             $realtime, got.calibrating, got.heading_valid, got.heading,
                             got.led_row, got.led_col);
            end
            else
            begin
                want = expected_headings.pop_front();
                if (got.calibrating !== want.calibrating ||
                    got.heading_valid !== want.heading_valid ||
                    got.heading !== want.heading ||
                    got.led_row !== want.led_row ||
                    got.led_col !== want.led_col)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: expected cal=%0d hv=%0d h=%0d rc=%0d,%0d got cal=%0d hv=%0d h=%0d rc=%0d,%0d",
                                 $realtime, want.calibrating, want.heading_valid, want.heading,
                                 want.led_row, want.led_col, got.calibrating,
                                 got.heading_valid, got.heading, got.led_row, got.led_col);
                end
            end
        end
    end

    // Stimulus: reset, directed rows, random items, drain
    initial
    begin
        int                      sent, k, n, kind, cx, cy;
        logic signed [MAG_W-1:0] rx, ry;
        sample_ch.valid  <= 1'b0;
        sample_ch.opcode <= OP_SAMPLE;
        sample_ch.mag_x  <= '0;
        sample_ch.mag_y  <= '0;
        reset_compass();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[r])
            transfer_item(DIRECTED[r].opcode, DIRECTED[r].mag_x, DIRECTED[r].mag_y,
                          DIRECTED[r].typed, DIRECTED[r].want);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // switch idling on and off in windows; none near the end
            if (sent % 50 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (sent >= RANDOM_ITEMS - 100)
                calm = 1'b1;

            if ($urandom_range(0, 24) == 0)
            begin
                // calibration pass around a random center, sometimes empty
                n  = $urandom_range(0, 12);
                cx = int'($urandom_range(0, 40000)) - 20000;
                cy = int'($urandom_range(0, 40000)) - 20000;
                transfer_item(OP_ENTER, MAG_W'($urandom()), MAG_W'($urandom()), 1'b0, '0);
                for (k = 0; k < n; k++)
                    transfer_item(OP_SAMPLE, MAG_W'(cx + int'($urandom_range(0, 4000)) - 2000),
                                  MAG_W'(cy + int'($urandom_range(0, 4000)) - 2000), 1'b0, '0);
                transfer_item(OP_ENTER, MAG_W'($urandom()), MAG_W'($urandom()), 1'b0, '0);
                sent += n + 2;
            end
            else
            begin
                kind = $urandom_range(0, 9);
                if (kind <= 5)
                begin
                    rx = MAG_W'($urandom());
                    ry = MAG_W'($urandom());
                end
                else if (kind <= 7)
                begin
                    // land near the offsets to hit the axis and zero cases
                    rx = off_x + MAG_W'($urandom_range(0, 6)) - MAG_W'(3);
                    ry = off_y + MAG_W'($urandom_range(0, 6)) - MAG_W'(3);
                end
                else if (kind == 8)
                begin
                    rx = $urandom_range(0, 1) ? off_x : MAG_W'($urandom());
                    ry = (rx == off_x) ? MAG_W'($urandom()) : off_y;
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0: rx = -16'sd32768;
                        1: rx = 16'sd32767;
                        2: rx = 16'sd0;
                        default: rx = -16'sd1;
                    endcase
                    case ($urandom_range(0, 3))
                        0: ry = -16'sd32768;
                        1: ry = 16'sd32767;
                        2: ry = 16'sd0;
                        default: ry = -16'sd1;
                    endcase
                end
                transfer_item(OP_SAMPLE, rx, ry, 1'b0, '0);
                sent++;
            end
        end
        sample_ch.valid <= 1'b0;

        while (expected_headings.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
